// ===== rtl/itrs_pkg.sv =====
// ---------------------------------------------------------------------------
// itrs_pkg: shared constants, types and functions
// sizes, ascii codes and the divider request and response structs
// ---------------------------------------------------------------------------
package itrs_pkg;

  localparam int WORD_WIDTH    = 32;
  localparam int MAX_DIGITS    = 32;
  localparam int VALUE_W       = 32;
  localparam int RADIX_W       = 6;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 8;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (WORD_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int ADDR_W        = $clog2(MAX_DIGITS);
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'h37;  // 'A' minus ten
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ERR_CHAR    = 8'h00;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return ASCII_ZERO + d_ext;
    end else begin
      return ASCII_ALPHA + d_ext;
    end
  endfunction

endpackage

// ===== rtl/integer_to_radix_string.sv =====
// ---------------------------------------------------------------------------
// integer_to_radix_string: signed integer to ascii string in radix 2 to 36
// repeated division by the radix, digits stored then sent msd first
// ---------------------------------------------------------------------------
// usage
//   input channel: in_value (signed) and in_radix, one transfer per string.
//   the block takes one item at a time; in_stall is high from the transfer
//   until the last character is loaded and while out_stall holds a character.
//   result channel: one transfer per character, out_last on the final one.
//   a radix outside 2..36 gives a single transfer with character 0,
//   out_last and out_error set.
//   radix 10 negative values get a leading '-', other radices treat the
//   value as unsigned.
// sequence
//   each digit is one pass of the divider, in steps of 8 quotient bits over
//   the 32-bit word, then a done strobe back to the sequencer.
//   each character is then a ram read, then an output load, with a '-'
//   loaded first; a bad radix loads its error result in the cycle after
//   the transfer.
// reset and stall
//   rst_n clears the sequencer, digit count and output valid; the digit ram
//   is not cleared since each entry is written before it is read.
//   while out_stall is high the output register holds its character and
//   the sequencer waits on it; no character is lost or repeated.
// ---------------------------------------------------------------------------
module integer_to_radix_string (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [itrs_pkg::VALUE_W-1:0] in_value,
  input  logic        [itrs_pkg::RADIX_W-1:0] in_radix,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [itrs_pkg::CHAR_W-1:0]  out_character,
  output logic                                out_last,
  output logic                                out_error
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [itrs_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          neg_r, neg_nxt;
  logic [itrs_pkg::RADIX_W-1:0]  radix_r, radix_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [itrs_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_err_r, out_err_nxt;

  itrs_pkg::div_req_t            div_req;
  itrs_pkg::div_rsp_t            div_rsp;

  logic                          ram_we;
  logic                          ram_re;
  logic [itrs_pkg::ADDR_W-1:0]   ram_raddr;
  logic [itrs_pkg::DIGIT_W-1:0]  ram_rdata;

  logic                          out_free;
  logic                          in_xfer;
  logic                          bad_radix;
  logic [itrs_pkg::WORD_WIDTH-1:0] word;
  logic                          word_neg;
  logic [itrs_pkg::WORD_WIDTH-1:0] magnitude;
  logic [itrs_pkg::CNT_W-1:0]    limit;

  // output register can take a new character this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;

  assign bad_radix = (in_radix < itrs_pkg::RADIX_MIN) || (in_radix > itrs_pkg::RADIX_MAX);

  // sign extend or truncate to the working word, magnitude only for base 10
  assign word      = itrs_pkg::WORD_WIDTH'(in_value);
  assign word_neg  = (in_radix == itrs_pkg::RADIX_DEC) && word[itrs_pkg::WORD_WIDTH-1];
  assign magnitude = word_neg ? itrs_pkg::WORD_WIDTH'(~word + itrs_pkg::WORD_WIDTH'(1))
                              : word;

  // the sign takes one place of the digit store
  assign limit = itrs_pkg::CNT_W'(itrs_pkg::MAX_DIGITS) - itrs_pkg::CNT_W'(neg_r);

  assign ram_raddr = itrs_pkg::ADDR_W'(count_r - itrs_pkg::CNT_W'(1));

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    neg_nxt          = neg_r;
    radix_nxt        = radix_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_char_nxt     = out_char_r;
    out_last_nxt     = out_last_r;
    out_err_nxt      = out_err_r;
    div_req.start    = 1'b0;
    div_req.dividend = itrs_pkg::DIV_W'(magnitude);
    div_req.divisor  = in_radix;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (bad_radix) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = itrs_pkg::ERR_CHAR;
            out_last_nxt  = 1'b1;
            out_err_nxt   = 1'b1;
          end else begin
            neg_nxt       = word_neg;
            radix_nxt     = in_radix;
            count_nxt     = '0;
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        // later passes divide by the radix held from the transfer
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = radix_r;
        if (div_rsp.done) begin
          // low order digits are kept when the store is full
          if (count_r < limit) begin
            ram_we    = 1'b1;
            count_nxt = count_r + itrs_pkg::CNT_W'(1);
          end
          if (div_rsp.quotient != '0) begin
            div_req.start = 1'b1;
          end else begin
            state_nxt = neg_r ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itrs_pkg::ASCII_MINUS;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itrs_pkg::digit_char(ram_rdata);
          out_last_nxt  = (count_r == itrs_pkg::CNT_W'(1));
          out_err_nxt   = 1'b0;
          count_nxt     = count_r - itrs_pkg::CNT_W'(1);
          state_nxt     = (count_r == itrs_pkg::CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      neg_r       <= 1'b0;
      radix_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      neg_r       <= neg_nxt;
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // character payload, no reset needed
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  itrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // digit store, least significant digit at address zero
  itrs_ram #(
    .WIDTH (itrs_pkg::DIGIT_W),
    .DEPTH (itrs_pkg::MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[itrs_pkg::ADDR_W-1:0]),
    .wdata (div_rsp.remainder),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

  // an accepted item always leads to work or to a loaded error result
  a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DIV) || (out_valid_r && out_err_r))
    else $error("accepted item started nothing");

  // divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide phase");

  // digit count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= itrs_pkg::CNT_W'(itrs_pkg::MAX_DIGITS))
    else $error("digit count beyond store depth");

  // emission never starts with an empty store
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (count_r != '0))
    else $error("read phase with no stored digits");

  // an error result always closes its string
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && (out_char_r == itrs_pkg::ERR_CHAR)))
    else $error("error result not a lone last character");

endmodule

// ===== rtl/itrs_ram.sv =====
// ---------------------------------------------------------------------------
// itrs_ram: generic single write, single read ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module itrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/itrs_div.sv =====
// ---------------------------------------------------------------------------
// itrs_div: iterative divider by a small radix
// restoring division, several quotient bits per cycle, remainder is the digit
// ---------------------------------------------------------------------------
module itrs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  itrs_pkg::div_req_t req,
  output itrs_pkg::div_rsp_t rsp
);

  logic [itrs_pkg::DIV_W-1:0]   q_r, q_nxt;
  logic [itrs_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [itrs_pkg::RADIX_W-1:0] dvs_r;
  logic [itrs_pkg::STEP_W-1:0]  step_r;
  logic                         busy_r;
  logic                         done_r;

  // one chunk of restoring division steps on the narrow remainder
  always_comb begin
    logic [itrs_pkg::DIGIT_W:0] r_w;
    logic [itrs_pkg::DIGIT_W:0] t_w;
    q_nxt = q_r;
    r_w   = {1'b0, rem_r};
    for (int j = 0; j < itrs_pkg::BITS_PER_STEP; j++) begin
      t_w   = {r_w[itrs_pkg::DIGIT_W-1:0], q_nxt[itrs_pkg::DIV_W-1]};
      q_nxt = {q_nxt[itrs_pkg::DIV_W-2:0], 1'b0};
      if (t_w >= {1'b0, dvs_r}) begin
        r_w      = t_w - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end else begin
        r_w = t_w;
      end
    end
    rem_nxt = r_w[itrs_pkg::DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + itrs_pkg::STEP_W'(1);
        if (step_r == itrs_pkg::STEP_W'(itrs_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== tb/itrs_char_checker.sv =====
// ---------------------------------------------------------------------------
// itrs_char_checker: character stream scoreboard for integer_to_radix_string
// works out the expected characters of every accepted value and radix and
// compares each transfer on the result channel with the oldest one due
// ---------------------------------------------------------------------------
module itrs_char_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic        [itrs_pkg::VALUE_W-1:0] in_value,
  input  logic        [itrs_pkg::RADIX_W-1:0] in_radix,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic        [itrs_pkg::CHAR_W-1:0]  out_character,
  input  logic                                out_last,
  input  logic                                out_error,
  output int                                  fail_count,
  output int                                  chars_pending,
  output int                                  strings_taken,
  output int                                  chars_checked,
  output int                                  bad_radix_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  import itrs_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam logic [36*CHAR_W-1:0] DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } char_exp_t;

  char_exp_t chars_due[$];

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    return DIGIT_SET[(35 - int'(d)) * CHAR_W +: CHAR_W];
  endfunction

  // digits least significant first, then queued most significant first
  function automatic void predict_string(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [DIGIT_W-1:0] digs [0:MAX_DIGITS-1];
    logic [WORD_WIDTH-1:0] mag;
    logic [WORD_WIDTH-1:0] rem;
    logic neg;
    int ndig;
    int cap;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      chars_due.push_back('{ch: ERR_CHAR, last: 1'b1, err: 1'b1});
      bad_radix_taken++;
      return;
    end
    neg  = (radix == RADIX_DEC) && value[VALUE_W-1];
    mag  = neg ? (~value + 1'b1) : value;
    cap  = MAX_DIGITS - (neg ? 1 : 0);
    ndig = 0;
    do begin
      rem = mag % radix;
      mag = mag / radix;
      if (ndig < cap) begin
        digs[ndig] = rem[DIGIT_W-1:0];
        ndig++;
      end
    end while (mag != 0);
    if (neg) begin
      chars_due.push_back('{ch: ASCII_MINUS, last: 1'b0, err: 1'b0});
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      chars_due.push_back('{ch: digit_ascii(digs[i]), last: (i == 0), err: 1'b0});
    end
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    char_exp_t want;
    if (!rst_n) begin
      chars_due.delete();
      fail_count      = 0;
      strings_taken   = 0;
      chars_checked   = 0;
      bad_radix_taken = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_string(in_value, in_radix);
        strings_taken++;
      end
      if (out_valid && !out_stall) begin
        chars_checked++;
        if (chars_due.size() == 0) begin
          note_failure($sformatf("unexpected char=%02h last=%0b error=%0b",
                                 out_character, out_last, out_error));
        end else begin
          want = chars_due.pop_front();
          if (out_character !== want.ch || out_last !== want.last ||
              out_error !== want.err) begin
            note_failure($sformatf("char exp %02h got %02h, last exp %0b got %0b, error exp %0b got %0b",
                                   want.ch, out_character, want.last, out_last,
                                   want.err, out_error));
          end
        end
      end
    end
    chars_pending = chars_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: top level testbench for integer_to_radix_string
// drives values and radices, stalls the character stream and gives a verdict
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itrs_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 300;   // longer than a full base 2 string
  localparam int RANDOM_PHASES    = 3;
  localparam int PHASE_ITEMS      = 30;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [VALUE_W-1:0]  in_value;
  logic        [RADIX_W-1:0]  in_radix;
  logic                       out_valid;
  logic                       out_stall;
  logic        [CHAR_W-1:0]   out_character;
  logic                       out_last;
  logic                       out_error;

  int fail_count;
  int chars_pending;
  int strings_taken;
  int chars_checked;
  int bad_radix_taken;
  int cycle_count;

  // pacing controls from the main sequence for the two sides
  logic quiet_send;
  logic quiet_recv;
  logic long_hold_req;

  integer_to_radix_string DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  itrs_char_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_radix        (in_radix),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_character   (out_character),
    .out_last        (out_last),
    .out_error       (out_error),
    .fail_count      (fail_count),
    .chars_pending   (chars_pending),
    .strings_taken   (strings_taken),
    .chars_checked   (chars_checked),
    .bad_radix_taken (bad_radix_taken)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d characters still due", cycle_count,
                 chars_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // gap length: mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // result side: random stall, a quiet phase, and the long hold-off on request
  initial begin
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        // block fills up behind this and must stall its input
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else if (quiet_recv) begin
        out_stall = 1'b0;
      end else begin
        out_stall = (pick_gap() != 0);
        if (out_stall) begin
          repeat (pick_gap()) @(negedge clk);
        end
      end
    end
  end

  // one transfer on the input channel; valid is left high on return
  task automatic send_string(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
    @(negedge clk);
    in_valid = 1'b1;
    in_value = v;
    in_radix = r;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid between items, scrambling the idle payload
  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_value = $urandom;
      in_radix = RADIX_W'($urandom_range(0, 63));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic offer(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
    send_string(v, r);
    pause_sender(quiet_send ? 0 : pick_gap());
  endtask

  // sender holds off until every character due has come out
  task automatic wait_all_chars();
    @(negedge clk);
    in_valid = 1'b0;
    wait (chars_pending == 0);
  endtask

  // random value and radix, weighted towards well-formed conversions
  task automatic pick_item(output logic [VALUE_W-1:0] v, output logic [RADIX_W-1:0] r);
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 1000);
      6:          v = -$urandom_range(1, 1000);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default:    v = $urandom >> $urandom_range(0, 31);
    endcase
    kind = $urandom_range(0, 19);
    case (kind)
      0, 1:       r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                           : RADIX_W'($urandom_range(37, 63));
      2, 3, 4, 5: r = RADIX_DEC;
      6, 7:       r = RADIX_MIN;
      8:          r = RADIX_MAX;
      default:    r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endcase
  endtask

  initial begin
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    in_valid      = 1'b0;
    in_value      = '0;
    in_radix      = '0;
    rst_n         = 1'b0;
    quiet_send    = 1'b0;
    quiet_recv    = 1'b0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // decimal: zero, both ends of the range, minus one and a plain negative
    offer(32'd0, RADIX_DEC);
    offer(32'h7FFF_FFFF, RADIX_DEC);
    offer(32'h8000_0000, RADIX_DEC);
    offer(32'hFFFF_FFFF, RADIX_DEC);
    offer(-32'sd1000000, RADIX_DEC);
    // other bases read the value as unsigned; all ones in base 2 is the longest
    offer(32'hFFFF_FFFF, RADIX_MIN);
    offer(32'h8000_0000, RADIX_MIN);
    offer(32'hFFFF_FFFF, 6'd16);
    offer(32'hFFFF_FFFF, RADIX_MAX);
    offer(-32'sd12345, 6'd16);
    offer(32'd0, RADIX_MIN);
    offer(32'd0, RADIX_MAX);
    offer(32'd35, RADIX_MAX);
    offer(32'd36, RADIX_MAX);
    offer(32'd10, 6'd11);
    offer(32'd1, 6'd3);
    offer(32'h5555_5555, 6'd7);
    offer(32'hAAAA_AAAA, 6'd9);
    // radix out of range: single error transfer
    offer(32'd1, 6'd0);
    offer(32'd1, 6'd1);
    offer(32'd5, 6'd37);
    offer(32'hFFFF_FFFF, 6'd63);

    // sender pause until the stream is empty
    wait_all_chars();

    // long hold-off on the result side while long strings keep coming
    long_hold_req = 1'b1;
    offer(32'hFFFF_FFFF, RADIX_MIN);
    offer(32'h8000_0000, RADIX_DEC);
    offer(32'h1234_5678, RADIX_MIN);
    offer(32'd7, 6'd40);
    offer(32'hDEAD_BEEF, 6'd5);
    offer(32'hFFFF_FFFF, RADIX_MIN);
    wait_all_chars();

    // random phases; the middle one runs with no idling on either side
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet_send = (ph == 1);
      quiet_recv = (ph == 1);
      repeat (PHASE_ITEMS) begin
        pick_item(v, r);
        offer(v, r);
      end
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;

    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d strings (%0d with a rejected radix), %0d characters checked",
             strings_taken, bad_radix_taken, chars_checked);
    $display("covered: directed extremes, a %0d-cycle result hold-off, %0d random phases",
             LONG_HOLD_CYCLES, RANDOM_PHASES);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d characters still due", fail_count, chars_pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itrs_pkg.sv
rtl/itrs_ram.sv
rtl/itrs_div.sv
rtl/integer_to_radix_string.sv
tb/itrs_char_checker.sv
tb/tb.sv
